[design/bilinear_wrap_texture_sampler_macros.svh]
// assertion macros for the bilinear wrap texture sampler
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BWTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("bwts assertion failed");
`define BWTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwts assertion failed");
`else
`define BWTS_ASSERT_IMP(lbl, ante, cons)
`define BWTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[design/bwts_pkg.sv]
// shared types, constants and helpers of the bilinear wrap texture sampler
package bwts_pkg;

    localparam int MAX_SIDE  = 256;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int SIZE_W    = SIDE_W + 1;
    localparam int CFG_W     = 9;
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int TEX_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int POS_W     = FRAC_BITS + SIZE_W;
    localparam int H_W       = CH_W + FRAC_BITS;

    localparam logic [CH_W-1:0] GRAY_LEVEL = 8'd128;

    // channel 2 red, 1 green, 0 blue
    typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    typedef enum logic [0:0] {
        REG_TEX_WIDTH  = 1'b0,
        REG_TEX_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic wr;
        logic smp;
        logic clr;
    } ctl_t;

    // zero counts as one, anything above the store side saturates
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [SIZE_W-1:0] s;
        if (r == '0)
            s = SIZE_W'(1);
        else if (r > CFG_W'(MAX_SIDE))
            s = SIZE_W'(MAX_SIDE);
        else
            s = r[SIZE_W-1:0];
        return s;
    endfunction

endpackage

[design/bwts_axis.sv]
// one axis of the address stage: scaled position, neighbour indices and weight
module bwts_axis
    import bwts_pkg::*;
(
    input  logic                 clk,
    input  logic [FRAC_BITS-1:0] frac,
    input  logic [SIZE_W-1:0]    size,
    output logic [SIDE_W-1:0]    idx0,
    output logic [SIDE_W-1:0]    idx1,
    output logic [FRAC_BITS-1:0] weight
);

    localparam logic [POS_W-1:0] HALF = POS_W'(1) << (FRAC_BITS - 1);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [SIZE_W-1:0] hi;

    // position plus half a texel, never negative
    assign pos_next = POS_W'(frac) * POS_W'(size) + HALF;

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
    end

    assign hi = pos_reg[POS_W-1:FRAC_BITS];

    // wrap minus one to the last texel and size to the first
    assign idx0   = (hi == '0) ? SIDE_W'(size - 1'b1) : SIDE_W'(hi - 1'b1);
    assign idx1   = (hi >= size) ? '0 : hi[SIDE_W-1:0];
    assign weight = pos_reg[FRAC_BITS-1:0];

endmodule

[design/bwts_texram.sv]
// one copy of the texel store, one write port and one registered read port
module bwts_texram
    import bwts_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  rgb_t              wdata,
    input  logic [ADDR_W-1:0] raddr,
    output rgb_t              rdata
);

    rgb_t mem [TEX_DEPTH];
    rgb_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bwts_blend.sv]
// two blend stages: horizontal then vertical per channel, gray when unloaded
module bwts_blend
    import bwts_pkg::*;
(
    input  logic                 clk,
    input  rgb_t                 c00,
    input  rgb_t                 c10,
    input  rgb_t                 c01,
    input  rgb_t                 c11,
    input  logic [FRAC_BITS-1:0] sx,
    input  logic [FRAC_BITS-1:0] sy,
    input  logic                 gray,
    output rgb_t                 result
);

    localparam int P1_W = H_W + 2;
    localparam int P2_W = H_W + FRAC_BITS + 2;

    logic [NUM_CH-1:0][H_W-1:0] h0_reg;
    logic [NUM_CH-1:0][H_W-1:0] h0_next;
    logic [NUM_CH-1:0][H_W-1:0] h1_reg;
    logic [NUM_CH-1:0][H_W-1:0] h1_next;
    logic [FRAC_BITS-1:0]       sy_reg;
    logic                       gray_reg;
    rgb_t                       result_reg;
    rgb_t                       result_next;

    function automatic logic [H_W-1:0] lerp_x(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [FRAC_BITS-1:0] s);
        logic signed [CH_W:0]   d;
        logic signed [P1_W-1:0] acc;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        acc = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + d * $signed({1'b0, s});
        return acc[H_W-1:0];
    endfunction

    // exact sum is a convex mix, so the top byte is the truncated result
    function automatic logic [CH_W-1:0] lerp_y(input logic [H_W-1:0] a,
                                               input logic [H_W-1:0] b,
                                               input logic [FRAC_BITS-1:0] s);
        logic signed [H_W:0]    d;
        logic signed [P2_W-1:0] acc;
        d   = $signed({1'b0, b}) - $signed({1'b0, a});
        acc = $signed({2'b00, a, {FRAC_BITS{1'b0}}}) + d * $signed({1'b0, s});
        return acc[H_W+FRAC_BITS-1 -: CH_W];
    endfunction

    always_comb
    begin
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            h0_next[ch]     = lerp_x(c00[ch], c10[ch], sx);
            h1_next[ch]     = lerp_x(c01[ch], c11[ch], sx);
            result_next[ch] = gray_reg ? GRAY_LEVEL : lerp_y(h0_reg[ch], h1_reg[ch], sy_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        h0_reg     <= h0_next;
        h1_reg     <= h1_next;
        sy_reg     <= sy;
        gray_reg   <= gray;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

[design/bilinear_wrap_texture_sampler.sv]
// Bilinear texture sampler with wrap addressing. One item is taken in every clock
// cycle (busy stays low) and a sample item gives its filtered colour on out_red,
// out_green and out_blue for one cycle with done high, once it has left the blend
// stages; write and clear items give nothing. The rate is set by the four
// copies of the 64K x 24 texel store, one per neighbour, each with one read port;
// every texel write goes to all four. Items take effect in order, so a sample sees
// every earlier write and clear. There is no clearing pass after reset: a texel
// that was never written reads back as garbage. Results cannot be held off, so
// the receiver must take each one in the cycle it is shown.
`include "bilinear_wrap_texture_sampler_macros.svh"

module bilinear_wrap_texture_sampler
    import bwts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic [1:0]          opcode,
    input  logic [COORD_W-1:0]  coord_u,
    input  logic [COORD_W-1:0]  coord_v,
    input  logic [SIDE_W-1:0]   texel_x,
    input  logic [SIDE_W-1:0]   texel_y,
    input  logic [CH_W-1:0]     texel_red,
    input  logic [CH_W-1:0]     texel_green,
    input  logic [CH_W-1:0]     texel_blue,
    output logic [CH_W-1:0]     out_red,
    output logic [CH_W-1:0]     out_green,
    output logic [CH_W-1:0]     out_blue,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_addr,
    input  logic [CFG_W-1:0]    cfg_wdata
);

    logic [CFG_W-1:0]     tex_width_reg;
    logic [CFG_W-1:0]     tex_height_reg;
    logic [SIZE_W-1:0]    width_eff;
    logic [SIZE_W-1:0]    height_eff;

    ctl_t                 ctl_in;
    ctl_t                 ctl1_reg;
    ctl_t                 ctl2_reg;
    logic [FRAC_BITS-1:0] ufrac1_reg;
    logic [FRAC_BITS-1:0] vfrac1_reg;
    logic [ADDR_W-1:0]    waddr1_reg;
    logic [ADDR_W-1:0]    waddr2_reg;
    rgb_t                 wrgb1_reg;
    rgb_t                 wrgb2_reg;
    logic                 loaded_reg;

    logic [SIDE_W-1:0]    x0;
    logic [SIDE_W-1:0]    x1;
    logic [SIDE_W-1:0]    y0;
    logic [SIDE_W-1:0]    y1;
    logic [FRAC_BITS-1:0] sx2;
    logic [FRAC_BITS-1:0] sy2;

    logic                 smp3_reg;
    logic                 gray3_reg;
    logic [FRAC_BITS-1:0] sx3_reg;
    logic [FRAC_BITS-1:0] sy3_reg;
    rgb_t                 c00;
    rgb_t                 c10;
    rgb_t                 c01;
    rgb_t                 c11;

    logic                 smp4_reg;
    logic                 done_reg;
    rgb_t                 result;

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= CFG_W'(1);
            tex_height_reg <= CFG_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_wdata;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_wdata;
            endcase
        end
    end

    assign width_eff  = eff_size(tex_width_reg);
    assign height_eff = eff_size(tex_height_reg);

    // opcode decode, an unused code becomes a bubble
    always_comb
    begin
        ctl_in = '0;
        if (start && !busy)
        begin
            unique case (opcode)
                OP_WRITE:  ctl_in.wr  = 1'b1;
                OP_SAMPLE: ctl_in.smp = 1'b1;
                OP_CLEAR:  ctl_in.clr = 1'b1;
                default:   ctl_in     = '0;
            endcase
        end
    end

    // stage 1: input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
        end
        else
        begin
            ctl1_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        ufrac1_reg <= coord_u[FRAC_BITS-1:0];
        vfrac1_reg <= coord_v[FRAC_BITS-1:0];
        waddr1_reg <= {texel_y, texel_x};
        wrgb1_reg  <= {texel_red, texel_green, texel_blue};
    end

    // stage 2: scaled positions live in the axis units
    bwts_axis u_axis_x
    (
        .clk    (clk),
        .frac   (ufrac1_reg),
        .size   (width_eff),
        .idx0   (x0),
        .idx1   (x1),
        .weight (sx2)
    );

    bwts_axis u_axis_y
    (
        .clk    (clk),
        .frac   (vfrac1_reg),
        .size   (height_eff),
        .idx0   (y0),
        .idx1   (y1),
        .weight (sy2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl2_reg <= '0;
        end
        else
        begin
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr2_reg <= waddr1_reg;
        wrgb2_reg  <= wrgb1_reg;
    end

    // loaded flag changes at the same stage where samples look at it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
        end
        else if (ctl2_reg.wr)
        begin
            loaded_reg <= 1'b1;
        end
        else if (ctl2_reg.clr)
        begin
            loaded_reg <= 1'b0;
        end
    end

    // stage 3: four store copies, one per neighbour
    bwts_texram u_ram00
    (
        .clk   (clk),
        .we    (ctl2_reg.wr),
        .waddr (waddr2_reg),
        .wdata (wrgb2_reg),
        .raddr ({y0, x0}),
        .rdata (c00)
    );

    bwts_texram u_ram10
    (
        .clk   (clk),
        .we    (ctl2_reg.wr),
        .waddr (waddr2_reg),
        .wdata (wrgb2_reg),
        .raddr ({y0, x1}),
        .rdata (c10)
    );

    bwts_texram u_ram01
    (
        .clk   (clk),
        .we    (ctl2_reg.wr),
        .waddr (waddr2_reg),
        .wdata (wrgb2_reg),
        .raddr ({y1, x0}),
        .rdata (c01)
    );

    bwts_texram u_ram11
    (
        .clk   (clk),
        .we    (ctl2_reg.wr),
        .waddr (waddr2_reg),
        .wdata (wrgb2_reg),
        .raddr ({y1, x1}),
        .rdata (c11)
    );

    always_ff @(posedge clk)
    begin
        gray3_reg <= !loaded_reg;
        sx3_reg   <= sx2;
        sy3_reg   <= sy2;
    end

    // stages 4 and 5: blend
    bwts_blend u_blend
    (
        .clk    (clk),
        .c00    (c00),
        .c10    (c10),
        .c01    (c01),
        .c11    (c11),
        .sx     (sx3_reg),
        .sy     (sy3_reg),
        .gray   (gray3_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp3_reg <= 1'b0;
            smp4_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            smp3_reg <= ctl2_reg.smp;
            smp4_reg <= smp3_reg;
            done_reg <= smp4_reg;
        end
    end

    assign done      = done_reg;
    assign out_red   = result[2];
    assign out_green = result[1];
    assign out_blue  = result[0];

    `BWTS_ASSERT_IMP(a_sample_latency, start && !busy && opcode == OP_SAMPLE, ##5 done)
    `BWTS_ASSERT_NXT(a_no_spurious_done, !smp4_reg, !done)
    `BWTS_ASSERT_NXT(a_write_loads, ctl2_reg.wr, loaded_reg)
    `BWTS_ASSERT_NXT(a_clear_unloads, ctl2_reg.clr, !loaded_reg)
    `BWTS_ASSERT_IMP(a_ctl_onehot, 1'b1, $onehot0(ctl1_reg))

endmodule
